### hw/rtl/mm_pkg.sv
// mm_pkg: shared types, codes and microcode ROM for the matrix multiply block.
// Used by matrix_multiply; no dependencies.

package mm_pkg;

    // Default matrix dimension limit
    localparam int MAX_DIM_DEF = 8;

    // Input item kinds
    localparam logic [1:0] KIND_LOAD_A  = 2'd0;
    localparam logic [1:0] KIND_LOAD_B  = 2'd1;
    localparam logic [1:0] KIND_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ROWS_A     = 2'd0;
    localparam logic [1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [1:0] CFG_COLS_B     = 2'd2;

    // Sequencer program counter
    localparam int PC_W = 3;
    typedef logic [PC_W-1:0] t_pc;

    // Jump conditions
    localparam logic [2:0] JC_NEXT   = 3'd0;  // fall through
    localparam logic [2:0] JC_ALWAYS = 3'd1;  // jump to target
    localparam logic [2:0] JC_WAIT   = 3'd2;  // jump unless a compute beat starts
    localparam logic [2:0] JC_KLOOP  = 3'd3;  // jump while inner index has more terms
    localparam logic [2:0] JC_EMIT   = 3'd4;  // hold while output full, else loop or finish

    // Step addresses
    localparam t_pc PC_WAIT  = 3'd0;
    localparam t_pc PC_START = 3'd1;
    localparam t_pc PC_ELEM  = 3'd2;
    localparam t_pc PC_READ  = 3'd3;
    localparam t_pc PC_MUL   = 3'd4;
    localparam t_pc PC_ACC   = 3'd5;
    localparam t_pc PC_EMIT  = 3'd6;

    // One control word
    typedef struct packed {
        logic       clr_rc;   // clear row/col counters
        logic       clr_k;    // clear inner counter and accumulator
        logic       rd;       // read A and B stores
        logic       mul;      // register the product
        logic       acc;      // accumulate, step inner counter
        logic       emit;     // load output register, step row/col
        logic [2:0] jc;
        t_pc        target;
    } t_uop;

    // Microcode ROM
    function automatic t_uop ucode(input t_pc pc);
        t_uop u;
        u = '0;
        case (pc)
            PC_WAIT: begin
                u.jc = JC_WAIT;    u.target = PC_WAIT;
            end
            PC_START: begin
                u.clr_rc = 1'b1;   u.jc = JC_NEXT;
            end
            PC_ELEM: begin
                u.clr_k = 1'b1;    u.jc = JC_NEXT;
            end
            PC_READ: begin
                u.rd = 1'b1;       u.jc = JC_NEXT;
            end
            PC_MUL: begin
                u.mul = 1'b1;      u.jc = JC_NEXT;
            end
            PC_ACC: begin
                u.acc = 1'b1;      u.jc = JC_KLOOP;  u.target = PC_READ;
            end
            PC_EMIT: begin
                u.emit = 1'b1;     u.jc = JC_EMIT;   u.target = PC_ELEM;
            end
            default: begin
                u.jc = JC_ALWAYS;  u.target = PC_WAIT;
            end
        endcase
        return u;
    endfunction

endpackage

### hw/rtl/matrix_multiply.sv
// matrix_multiply: signed Q16.16 matrix product C = A * B, microcoded sequencer.
// Depends on mm_pkg (control word type, ROM, kind and register codes).
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall) carries beats of kind, row, col,
//    value. Kind 0 writes A[row][col], kind 1 writes B[row][col]; a load with
//    row or col at MAX_DIM or above is dropped, kind 3 is dropped.
//  - Kind 2 starts a run: the block sends rows_a * cols_b result beats on the
//    output channel (o_out_valid / i_out_stall) in row-major order, o_last set
//    on the final one. Values are floored per product, summed in 64 bits and
//    saturated to 32 bits.
//  - Loads are taken back to back while the sequencer is idle. During a run
//    each inner term walks the
//    read / multiply / accumulate steps of the shared 32x32 multiplier,
//    plus two steps per product element; o_in_stall stays high meanwhile.
//  - First result is registered after the start, element, per-term and emit steps.
//  - A single output register holds each result; while it is full and i_out_stall
//    is high the sequencer waits on its emit step and nothing is lost.
//  - Size registers (rows_a, inner_size, cols_b) reset to 3; 0 acts as 1 and values above
//    MAX_DIM act as MAX_DIM. Write them only while idle; the block does not enforce it.
//  - Reset (i_rst_n low, synchronous) returns the sequencer to idle and
//    empties the output register; the element stores are not cleared.

module matrix_multiply #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [3:0]  i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [2:0]  i_row,
    input  logic [2:0]  i_col,
    input  logic [31:0] i_value,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_out_row,
    output logic [2:0]  o_out_col,
    output logic [31:0] o_out_value,
    output logic        o_last
);
    import mm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // clamp a size register and return size minus one
    function automatic logic [AW-1:0] dim_m1(input logic [3:0] v);
        logic [3:0] t;
        if (v == 4'd0)
            t = 4'd1;
        else if (v > 4'(MAX_DIM))
            t = 4'(MAX_DIM);
        else
            t = v;
        return AW'(t - 4'd1);
    endfunction

    // configuration registers
    logic [3:0] r_rows_a, r_inner_size, r_cols_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a     <= 4'd3;
            r_inner_size <= 4'd3;
            r_cols_b     <= 4'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS_A:     r_rows_a     <= i_cfg_data;
                CFG_INNER_SIZE: r_inner_size <= i_cfg_data;
                CFG_COLS_B:     r_cols_b     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [AW-1:0] nr_m1, nk_m1, nc_m1;
    assign nr_m1 = dim_m1(r_rows_a);
    assign nk_m1 = dim_m1(r_inner_size);
    assign nc_m1 = dim_m1(r_cols_b);

    // sequencer state
    t_pc           r_pc, n_pc;
    t_uop          uop;
    logic [AW-1:0] r_r, r_c, r_k;
    logic          r_out_valid;

    assign uop = ucode(r_pc);

    // input handshake
    logic in_acc, start, load_a, load_b, load_ok;
    assign o_in_stall = (r_pc != PC_WAIT);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign start      = in_acc && (i_kind == KIND_COMPUTE);
    assign load_ok    = ({1'b0, i_row} < 4'(MAX_DIM)) && ({1'b0, i_col} < 4'(MAX_DIM));
    assign load_a     = in_acc && (i_kind == KIND_LOAD_A) && load_ok;
    assign load_b     = in_acc && (i_kind == KIND_LOAD_B) && load_ok;

    // output register free this cycle
    logic out_free, emit_fire, elem_last;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign emit_fire = uop.emit && out_free;
    assign elem_last = (r_r == nr_m1) && (r_c == nc_m1);

    // next step
    always_comb begin
        n_pc = r_pc + t_pc'(1);
        case (uop.jc)
            JC_NEXT:   n_pc = r_pc + t_pc'(1);
            JC_ALWAYS: n_pc = uop.target;
            JC_WAIT:   if (!start) n_pc = uop.target;
            JC_KLOOP:  if (r_k != nk_m1) n_pc = uop.target;
            JC_EMIT: begin
                if (!out_free)
                    n_pc = r_pc;
                else if (elem_last)
                    n_pc = PC_WAIT;
                else
                    n_pc = uop.target;
            end
            default:   n_pc = PC_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_pc <= PC_WAIT;
        else
            r_pc <= n_pc;
    end

    // loop counters
    always_ff @(posedge i_clk) begin
        if (uop.clr_rc) begin
            r_r <= '0;
            r_c <= '0;
        end else if (emit_fire) begin
            if (r_c == nc_m1) begin
                r_c <= '0;
                r_r <= AW'(r_r + 1'b1);
            end else begin
                r_c <= AW'(r_c + 1'b1);
            end
        end
        if (uop.clr_k)
            r_k <= '0;
        else if (uop.acc)
            r_k <= AW'(r_k + 1'b1);
    end

    // element stores
    logic [31:0]      mem_a [DEPTH];
    logic [31:0]      mem_b [DEPTH];
    logic [ADR_W-1:0] wr_adr, rd_adr_a, rd_adr_b;
    logic [31:0]      r_a_rd, r_b_rd;

    assign wr_adr   = ADR_W'(i_row[AW-1:0]) * ADR_W'(MAX_DIM) + ADR_W'(i_col[AW-1:0]);
    assign rd_adr_a = ADR_W'(r_r) * ADR_W'(MAX_DIM) + ADR_W'(r_k);
    assign rd_adr_b = ADR_W'(r_k) * ADR_W'(MAX_DIM) + ADR_W'(r_c);

    always_ff @(posedge i_clk) begin
        if (load_a)
            mem_a[wr_adr] <= i_value;
        if (uop.rd)
            r_a_rd <= mem_a[rd_adr_a];
    end

    always_ff @(posedge i_clk) begin
        if (load_b)
            mem_b[wr_adr] <= i_value;
        if (uop.rd)
            r_b_rd <= mem_b[rd_adr_b];
    end

    // multiply, then floor to Q16.16 and accumulate
    logic signed [63:0] r_prod, r_acc;

    always_ff @(posedge i_clk) begin
        if (uop.mul)
            r_prod <= $signed(r_a_rd) * $signed(r_b_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_acc <= '0;
        else if (uop.clr_k)
            r_acc <= '0;
        else if (uop.acc)
            r_acc <= r_acc + (r_prod >>> 16);
    end

    // saturate to 32 bits
    logic [31:0] sat_val;
    always_comb begin
        if (r_acc[63:31] == {33{1'b0}} || r_acc[63:31] == {33{1'b1}})
            sat_val = r_acc[31:0];
        else if (r_acc[63])
            sat_val = 32'h8000_0000;
        else
            sat_val = 32'h7FFF_FFFF;
    end

    // output register
    logic [2:0]  r_out_row, r_out_col;
    logic [31:0] r_out_value;
    logic        r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (emit_fire)
            r_out_valid <= 1'b1;
        else if (!i_out_stall)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_out_row   <= 3'(r_r);
            r_out_col   <= 3'(r_c);
            r_out_value <= sat_val;
            r_last      <= elem_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_value;
    assign o_last      = r_last;

endmodule
